// ===== design/kwsc_pkg.sv =====
// package: constants, microcode types and the control program of the keyword cipher
`default_nettype none

package kwsc_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int IDX_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int PC_W        = 3;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_KEY   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEXT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // program step addresses
  localparam logic [PC_W-1:0] STEP_FETCH  = 3'd0;
  localparam logic [PC_W-1:0] STEP_DECODE = 3'd1;
  localparam logic [PC_W-1:0] STEP_KEY    = 3'd2;
  localparam logic [PC_W-1:0] STEP_CLEAR  = 3'd3;
  localparam logic [PC_W-1:0] STEP_TEXT   = 3'd4;
  localparam logic [PC_W-1:0] STEP_FILL   = 3'd5;
  localparam logic [PC_W-1:0] STEP_LOOKUP = 3'd6;
  localparam logic [PC_W-1:0] STEP_EMIT   = 3'd7;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_PLACE_KEY,
    ACT_PLACE_FILL,
    ACT_CLEAR,
    ACT_READ,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_COMPLETE,
    COND_FILL_MORE,
    COND_OUT_BUSY,
    COND_DISPATCH
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] jump;
    logic [PC_W-1:0] next;
  } ctrl_word_t;

  // control store: jump when the condition holds, else go to next
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    begin
      case (pc)
        STEP_FETCH:  w = '{ACT_LOAD,       COND_NO_ITEM,   STEP_FETCH,  STEP_DECODE};
        STEP_DECODE: w = '{ACT_NONE,       COND_DISPATCH,  STEP_FETCH,  STEP_FETCH};
        STEP_KEY:    w = '{ACT_PLACE_KEY,  COND_ALWAYS,    STEP_FETCH,  STEP_FETCH};
        STEP_CLEAR:  w = '{ACT_CLEAR,      COND_ALWAYS,    STEP_FETCH,  STEP_FETCH};
        STEP_TEXT:   w = '{ACT_NONE,       COND_COMPLETE,  STEP_LOOKUP, STEP_FILL};
        STEP_FILL:   w = '{ACT_PLACE_FILL, COND_FILL_MORE, STEP_FILL,   STEP_LOOKUP};
        STEP_LOOKUP: w = '{ACT_READ,       COND_ALWAYS,    STEP_EMIT,   STEP_EMIT};
        STEP_EMIT:   w = '{ACT_EMIT,       COND_OUT_BUSY,  STEP_EMIT,   STEP_FETCH};
        default:     w = '{ACT_NONE,       COND_ALWAYS,    STEP_FETCH,  STEP_FETCH};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/keyword_substitution_cipher_unit.sv =====
// top level: microcoded keyword substitution cipher with its two lookup tables
`default_nettype none

// keyword substitution cipher. items arrive on func/char_value (valid/stall) and
// are handled one at a time by a small microprogram, one control step per cycle.
// a keyword character or a clear runs the fetch, decode and execute steps before
// the next item can be accepted. a text character runs the fetch, decode, text,
// lookup and emit steps, and its result reaches the output register in the emit
// step. the first text character after a clear or reset also runs the table
// fill loop, one letter per cycle from Z down to A, between the text and lookup
// steps; each table has a single write port.
// a result waits in the output register while the next item is already accepted
// and worked on; only a second result stalls behind an untaken one.
// decrypt_mode is written through cfg_valid/cfg_ready/cfg_data and should only
// change while idle.
module keyword_substitution_cipher_unit (
  input  wire                          clk,
  input  wire                          rst,
  // item channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [kwsc_pkg::FUNC_W-1:0]  func,
  input  wire  [kwsc_pkg::CHAR_W-1:0]  char_value,
  // result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [kwsc_pkg::CHAR_W-1:0]  out_char,
  // configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_data
);

  // sequencer
  logic [kwsc_pkg::PC_W-1:0]   pc;
  logic [kwsc_pkg::PC_W-1:0]   pc_next;
  kwsc_pkg::ctrl_word_t        cw;
  logic                        cond_taken;

  // item held for the current transaction
  logic [kwsc_pkg::FUNC_W-1:0] func_reg;
  logic [kwsc_pkg::CHAR_W-1:0] char_reg;

  // table state
  logic [kwsc_pkg::NUM_LETTERS-1:0] letter_used;
  logic [kwsc_pkg::IDX_W-1:0]       key_length;
  logic                             table_complete;
  logic [kwsc_pkg::IDX_W-1:0]       fill_idx;
  logic                             decrypt_mode;

  logic [kwsc_pkg::IDX_W-1:0] cipher_table  [kwsc_pkg::NUM_LETTERS];
  logic [kwsc_pkg::IDX_W-1:0] inverse_table [kwsc_pkg::NUM_LETTERS];
  logic [kwsc_pkg::IDX_W-1:0] rd_cipher;
  logic [kwsc_pkg::IDX_W-1:0] rd_inverse;

  logic                       in_accept;
  logic                       out_busy;
  logic                       is_upper;
  logic                       is_lower;
  logic                       is_letter;
  logic [kwsc_pkg::CHAR_W-1:0] letter_base;
  logic [kwsc_pkg::CHAR_W-1:0] letter_off;
  logic [kwsc_pkg::IDX_W-1:0]  char_idx;
  logic [kwsc_pkg::IDX_W-1:0]  place_idx;
  logic                        place_req;
  logic                        place_en;
  logic [kwsc_pkg::IDX_W-1:0]  sub_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (pc != kwsc_pkg::STEP_FETCH);
  assign in_accept = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;

  // letter decode of the held character
  assign is_upper    = (char_reg >= kwsc_pkg::CHAR_UPPER_A) && (char_reg <= kwsc_pkg::CHAR_UPPER_Z);
  assign is_lower    = (char_reg >= kwsc_pkg::CHAR_LOWER_A) && (char_reg <= kwsc_pkg::CHAR_LOWER_Z);
  assign is_letter   = is_upper || is_lower;
  assign letter_base = is_lower ? kwsc_pkg::CHAR_LOWER_A : kwsc_pkg::CHAR_UPPER_A;
  assign letter_off  = char_reg - letter_base;
  assign char_idx    = letter_off[kwsc_pkg::IDX_W-1:0];

  // one shared placement path for keyword letters and the fill loop
  assign cw        = kwsc_pkg::ucode(pc);
  assign place_idx = (cw.act == kwsc_pkg::ACT_PLACE_FILL) ? fill_idx : char_idx;
  assign place_req = ((cw.act == kwsc_pkg::ACT_PLACE_KEY) && is_letter && !table_complete)
                  || (cw.act == kwsc_pkg::ACT_PLACE_FILL);
  assign place_en  = place_req && !letter_used[place_idx]
                  && (key_length < kwsc_pkg::IDX_W'(kwsc_pkg::NUM_LETTERS));

  assign sub_idx = decrypt_mode ? rd_inverse : rd_cipher;

  // next step: condition selects jump or fall-through, decode dispatches on func
  always_comb begin
    case (cw.cond)
      kwsc_pkg::COND_ALWAYS:    cond_taken = 1'b1;
      kwsc_pkg::COND_NO_ITEM:   cond_taken = !in_accept;
      kwsc_pkg::COND_COMPLETE:  cond_taken = table_complete;
      kwsc_pkg::COND_FILL_MORE: cond_taken = (fill_idx != '0);
      kwsc_pkg::COND_OUT_BUSY:  cond_taken = out_busy;
      default:                  cond_taken = 1'b0;
    endcase
    if (cw.cond == kwsc_pkg::COND_DISPATCH) begin
      case (func_reg)
        kwsc_pkg::FUNC_KEY:   pc_next = kwsc_pkg::STEP_KEY;
        kwsc_pkg::FUNC_TEXT:  pc_next = kwsc_pkg::STEP_TEXT;
        kwsc_pkg::FUNC_CLEAR: pc_next = kwsc_pkg::STEP_CLEAR;
        default:              pc_next = kwsc_pkg::STEP_FETCH;
      endcase
    end else begin
      pc_next = cond_taken ? cw.jump : cw.next;
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= kwsc_pkg::STEP_FETCH;
      letter_used    <= '0;
      key_length     <= '0;
      table_complete <= 1'b0;
      decrypt_mode   <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) begin
        decrypt_mode <= cfg_data;
      end
      // a new result replaces the one taken in the same cycle
      if ((cw.act == kwsc_pkg::ACT_EMIT) && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (place_en) begin
        letter_used[place_idx] <= 1'b1;
        key_length             <= key_length + 1'b1;
      end
      case (cw.act)
        kwsc_pkg::ACT_CLEAR: begin
          letter_used    <= '0;
          key_length     <= '0;
          table_complete <= 1'b0;
        end
        kwsc_pkg::ACT_READ: begin
          table_complete <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // item capture, fill counter and result byte
  always_ff @(posedge clk) begin
    if ((cw.act == kwsc_pkg::ACT_LOAD) && in_accept) begin
      func_reg <= func;
      char_reg <= char_value;
      fill_idx <= kwsc_pkg::IDX_W'(kwsc_pkg::NUM_LETTERS - 1);
    end
    if (cw.act == kwsc_pkg::ACT_PLACE_FILL) begin
      fill_idx <= fill_idx - 1'b1;
    end
    if ((cw.act == kwsc_pkg::ACT_EMIT) && !out_busy) begin
      out_char <= is_letter ? (letter_base + {3'b000, sub_idx}) : char_reg;
    end
  end

  // lookup tables: one write and one registered read each
  always_ff @(posedge clk) begin
    if (place_en) begin
      cipher_table[key_length] <= place_idx;
      inverse_table[place_idx] <= key_length;
    end
    if (cw.act == kwsc_pkg::ACT_READ) begin
      rd_cipher  <= cipher_table[char_idx];
      rd_inverse <= inverse_table[char_idx];
    end
  end

`ifndef NO_ASSERTIONS
  // every placed letter is counted exactly once
  a_used_count : assert property (@(posedge clk) disable iff (rst)
    $countones(letter_used) == 32'(key_length))
    else $error("letter_used and key_length disagree");

  a_key_bound : assert property (@(posedge clk) disable iff (rst)
    key_length <= kwsc_pkg::IDX_W'(kwsc_pkg::NUM_LETTERS))
    else $error("key_length beyond alphabet");

  // a result appears only from the emit step
  a_emit_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pc) == kwsc_pkg::STEP_EMIT)
    else $error("result without emit step");

  // the fill loop only runs on an unfinished table
  a_fill_open : assert property (@(posedge clk) disable iff (rst)
    pc == kwsc_pkg::STEP_FILL |-> !table_complete)
    else $error("fill on finished table");

  // a finished table holds all letters
  a_complete_full : assert property (@(posedge clk) disable iff (rst)
    table_complete |-> key_length == kwsc_pkg::IDX_W'(kwsc_pkg::NUM_LETTERS))
    else $error("finished table is short");
`endif

endmodule

`default_nettype wire
